// ----- rtl/plt_pkg.sv -----
package plt_pkg;

    // Sample width and configuration register width
    localparam int unsigned PIX_W     = 8;
    localparam int unsigned CFG_W     = 48;
    localparam int unsigned MAX_KNOTS = 6;
    localparam int unsigned SEL_W     = 3;
    localparam int unsigned DIV_STEPS = PIX_W;

    // Default knot count for the top level
    localparam int unsigned NUM_KNOTS_DEF = 6;

    // Reset curve: x = 0, 50, 100, 150, 200, 255 / y = 0, 80, 150, 190, 220, 255
    localparam logic [CFG_W-1:0] KNOT_X_RST = 48'hFF_C8_96_64_32_00;
    localparam logic [CFG_W-1:0] KNOT_Y_RST = 48'hFF_DC_BE_96_50_00;

    // Configuration register indexes
    typedef enum logic [0:0] {
        CFG_KNOT_X = 1'b0,
        CFG_KNOT_Y = 1'b1
    } t_cfg_idx;

    // Item moving down the search chain
    typedef struct packed {
        logic [PIX_W-1:0] pix;
        logic             found;
        logic [SEL_W-1:0] sel;
    } t_srch_item;

    // Item after segment setup
    typedef struct packed {
        logic [PIX_W-1:0] t;
        logic [PIX_W-1:0] dx;
        logic [PIX_W-1:0] d;
        logic [PIX_W-1:0] yl;
        logic             neg;
        logic             direct;
    } t_seg_item;

    // Item moving down the divider chain
    typedef struct packed {
        logic [PIX_W-1:0] rem;
        logic [PIX_W-1:0] lo;
        logic [PIX_W-1:0] q;
        logic [PIX_W-1:0] dx;
        logic [PIX_W-1:0] yl;
        logic             neg;
        logic             direct;
    } t_div_item;

    // Byte k of a packed knot register
    function automatic logic [PIX_W-1:0] knot_field(
        input logic [CFG_W-1:0] packed_val,
        input logic [SEL_W-1:0] k
    );
        logic [CFG_W-1:0] sh;
        sh = packed_val >> {k, 3'b000};
        return sh[PIX_W-1:0];
    endfunction

endpackage

// ----- rtl/plt_search_cell.sv -----
module plt_search_cell #(
    parameter int unsigned IDX = 0
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  plt_pkg::t_srch_item  i_item,
    input  logic [plt_pkg::PIX_W-1:0] i_knot_x,
    output logic                 o_valid,
    input  logic                 i_ready,
    output plt_pkg::t_srch_item  o_item
);

    logic                r_valid;
    plt_pkg::t_srch_item r_item;
    plt_pkg::t_srch_item n_item;
    logic                en;

    // Stage moves when empty or when the next cell takes its contents
    assign en      = !r_valid || i_ready;
    assign o_ready = en;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    // First knot at or above the pixel claims the item
    always_comb begin
        n_item = i_item;
        if (!i_item.found && (i_knot_x >= i_item.pix)) begin
            n_item.found = 1'b1;
            n_item.sel   = plt_pkg::SEL_W'(IDX);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en && i_valid) begin
            r_item <= n_item;
        end
    end

endmodule

// ----- rtl/plt_div_cell.sv -----
module plt_div_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  plt_pkg::t_div_item  i_item,
    output logic                o_valid,
    input  logic                i_ready,
    output plt_pkg::t_div_item  o_item
);

    logic                   r_valid;
    plt_pkg::t_div_item     r_item;
    plt_pkg::t_div_item     n_item;
    logic [plt_pkg::PIX_W:0] cat;
    logic [plt_pkg::PIX_W:0] diff;
    logic                   en;

    assign en      = !r_valid || i_ready;
    assign o_ready = en;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    // One restoring division step: shift in next numerator bit, try subtract
    assign cat  = {i_item.rem, i_item.lo[plt_pkg::PIX_W-1]};
    assign diff = cat - {1'b0, i_item.dx};

    always_comb begin
        n_item    = i_item;
        n_item.lo = {i_item.lo[plt_pkg::PIX_W-2:0], 1'b0};
        if (cat >= {1'b0, i_item.dx}) begin
            n_item.rem = diff[plt_pkg::PIX_W-1:0];
            n_item.q   = {i_item.q[plt_pkg::PIX_W-2:0], 1'b1};
        end else begin
            n_item.rem = cat[plt_pkg::PIX_W-1:0];
            n_item.q   = {i_item.q[plt_pkg::PIX_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en && i_valid) begin
            r_item <= n_item;
        end
    end

endmodule

// ----- rtl/piecewise_linear_tone_curve_unit.sv -----
// Piecewise linear tone curve: each 8-bit pixel is mapped through NUM_KNOTS
// knots held in two packed registers (index 0 = knot x positions, index 1 =
// knot y values, knot 0 in the lowest byte). The unit takes one pixel per
// clock when nothing stalls. Each pixel passes one search cell per knot, a
// segment setup stage, a multiply stage, eight restoring divider cells (one
// quotient bit each) and the output register. Every stage is its own
// valid/stall slot, so bubbles close up and new pixels keep entering while a
// result waits at the output. Write the knot registers only while no
// transaction is in flight.
module piecewise_linear_tone_curve_unit #(
    parameter int unsigned NUM_KNOTS = plt_pkg::NUM_KNOTS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic                       i_cfg_idx,
    input  logic [plt_pkg::CFG_W-1:0]  i_cfg_data,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic [plt_pkg::PIX_W-1:0]  i_pixel_value,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic [plt_pkg::PIX_W-1:0]  o_mapped_value
);

    localparam int unsigned NDIV = plt_pkg::DIV_STEPS;

    // Configuration registers
    logic [plt_pkg::CFG_W-1:0] r_knot_x;
    logic [plt_pkg::CFG_W-1:0] r_knot_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_knot_x <= plt_pkg::KNOT_X_RST;
            r_knot_y <= plt_pkg::KNOT_Y_RST;
        end else if (i_cfg_we) begin
            unique case (plt_pkg::t_cfg_idx'(i_cfg_idx))
                plt_pkg::CFG_KNOT_X: r_knot_x <= i_cfg_data;
                plt_pkg::CFG_KNOT_Y: r_knot_y <= i_cfg_data;
                default:             r_knot_x <= r_knot_x;
            endcase
        end
    end

    // Search chain
    logic                s_valid [0:NUM_KNOTS];
    logic                s_ready [0:NUM_KNOTS];
    plt_pkg::t_srch_item s_item  [0:NUM_KNOTS];

    assign s_valid[0]       = i_valid;
    assign s_item[0].pix    = i_pixel_value;
    assign s_item[0].found  = 1'b0;
    assign s_item[0].sel    = '0;
    assign o_stall          = !s_ready[0];

    for (genvar k = 0; k < NUM_KNOTS; k++) begin : g_srch
        plt_search_cell #(
            .IDX (k)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_valid  (s_valid[k]),
            .o_ready  (s_ready[k]),
            .i_item   (s_item[k]),
            .i_knot_x (plt_pkg::knot_field(r_knot_x, plt_pkg::SEL_W'(k))),
            .o_valid  (s_valid[k+1]),
            .i_ready  (s_ready[k+1]),
            .o_item   (s_item[k+1])
        );
    end

    // Divider chain signals
    logic               d_valid [0:NDIV];
    logic               d_ready [0:NDIV];
    plt_pkg::t_div_item d_item  [0:NDIV];

    // Segment setup stage
    logic                  r_a_valid;
    plt_pkg::t_seg_item    r_a_item;
    plt_pkg::t_seg_item    n_a_item;
    logic                  a_en;
    logic                  b_en;
    plt_pkg::t_srch_item   sa;
    logic [plt_pkg::SEL_W-1:0] sel_lo;
    logic [plt_pkg::PIX_W-1:0] xl, xh, yl, yh;

    assign sa     = s_item[NUM_KNOTS];
    assign sel_lo = sa.sel - plt_pkg::SEL_W'(1);
    assign xh     = plt_pkg::knot_field(r_knot_x, sa.sel);
    assign yh     = plt_pkg::knot_field(r_knot_y, sa.sel);
    assign xl     = plt_pkg::knot_field(r_knot_x, sel_lo);
    assign yl     = plt_pkg::knot_field(r_knot_y, sel_lo);

    assign a_en               = !r_a_valid || b_en;
    assign s_ready[NUM_KNOTS] = a_en;

    always_comb begin
        n_a_item.t      = '0;
        n_a_item.dx     = plt_pkg::PIX_W'(1);
        n_a_item.d      = '0;
        n_a_item.neg    = 1'b0;
        n_a_item.direct = 1'b1;
        n_a_item.yl     = yh;
        if (!sa.found) begin
            // above the last knot
            n_a_item.yl = plt_pkg::knot_field(r_knot_y, plt_pkg::SEL_W'(NUM_KNOTS - 1));
        end else if ((sa.sel == '0) || (xh == sa.pix)) begin
            n_a_item.yl = yh;
        end else begin
            n_a_item.direct = 1'b0;
            n_a_item.yl     = yl;
            n_a_item.t      = sa.pix - xl;
            n_a_item.dx     = xh - xl;
            n_a_item.neg    = (yh < yl);
            n_a_item.d      = (yh < yl) ? (yl - yh) : (yh - yl);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (a_en) begin
            r_a_valid <= s_valid[NUM_KNOTS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_en && s_valid[NUM_KNOTS]) begin
            r_a_item <= n_a_item;
        end
    end

    // Multiply stage: numerator = t*d, plus dx-1 on a falling segment (ceiling)
    logic                        r_b_valid;
    plt_pkg::t_div_item          r_b_item;
    plt_pkg::t_div_item          n_b_item;
    logic [2*plt_pkg::PIX_W-1:0] num;

    assign b_en = !r_b_valid || d_ready[0];

    assign num = (2*plt_pkg::PIX_W)'(r_a_item.t) * (2*plt_pkg::PIX_W)'(r_a_item.d)
               + (r_a_item.neg ? (2*plt_pkg::PIX_W)'(r_a_item.dx - plt_pkg::PIX_W'(1))
                               : '0);

    always_comb begin
        n_b_item.rem    = num[2*plt_pkg::PIX_W-1:plt_pkg::PIX_W];
        n_b_item.lo     = num[plt_pkg::PIX_W-1:0];
        n_b_item.q      = '0;
        n_b_item.dx     = r_a_item.dx;
        n_b_item.yl     = r_a_item.yl;
        n_b_item.neg    = r_a_item.neg;
        n_b_item.direct = r_a_item.direct;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (b_en) begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_en && r_a_valid) begin
            r_b_item <= n_b_item;
        end
    end

    // Divider chain
    assign d_valid[0] = r_b_valid;
    assign d_item[0]  = r_b_item;

    for (genvar s = 0; s < NDIV; s++) begin : g_div
        plt_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (d_valid[s]),
            .o_ready (d_ready[s]),
            .i_item  (d_item[s]),
            .o_valid (d_valid[s+1]),
            .i_ready (d_ready[s+1]),
            .o_item  (d_item[s+1])
        );
    end

    // Output register
    logic                      r_o_valid;
    logic [plt_pkg::PIX_W-1:0] r_o_value;
    logic [plt_pkg::PIX_W-1:0] n_o_value;
    logic                      o_en;
    plt_pkg::t_div_item        dq;

    assign dq            = d_item[NDIV];
    assign o_en          = !r_o_valid || !i_stall;
    assign d_ready[NDIV] = o_en;

    always_comb begin
        if (dq.direct) begin
            n_o_value = dq.yl;
        end else if (dq.neg) begin
            n_o_value = dq.yl - dq.q;
        end else begin
            n_o_value = dq.yl + dq.q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (o_en) begin
            r_o_valid <= d_valid[NDIV];
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_en && d_valid[NDIV]) begin
            r_o_value <= n_o_value;
        end
    end

    assign o_valid        = r_o_valid;
    assign o_mapped_value = r_o_value;

    // Checks
    a_rst_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    a_seg_width: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_a_valid && !r_a_item.direct) |-> (r_a_item.dx != '0 && r_a_item.t < r_a_item.dx))
        else $error("interpolation segment malformed");

    a_num_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_b_valid && !r_b_item.direct) |-> (r_b_item.rem < r_b_item.dx))
        else $error("numerator overflows quotient width");

    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (d_valid[NDIV] && !dq.direct) |-> (dq.rem < dq.dx))
        else $error("divider remainder out of range");

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 100ps

module testbench;

    localparam int KNOTS     = plt_pkg::NUM_KNOTS_DEF;
    localparam int LATENCY   = KNOTS + 11;
    localparam logic [plt_pkg::CFG_W-1:0] ALL_ONES = {plt_pkg::CFG_W{1'b1}};

    // Shapes of randomly drawn curves
    typedef enum int {
        CURVE_RISING,
        CURVE_SCRAMBLED,
        CURVE_RAW,
        CURVE_EXTREME
    } t_curve_shape;

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        i_cfg_we;
    logic                        i_cfg_idx;
    logic [plt_pkg::CFG_W-1:0]   i_cfg_data;
    logic                        i_valid;
    logic                        o_stall;
    logic [plt_pkg::PIX_W-1:0]   i_pixel_value;
    logic                        o_valid;
    logic                        i_stall;
    logic [plt_pkg::PIX_W-1:0]   o_mapped_value;

    // Local copy of the knot registers
    logic [plt_pkg::CFG_W-1:0]   knot_x_reg;
    logic [plt_pkg::CFG_W-1:0]   knot_y_reg;

    logic [plt_pkg::PIX_W-1:0]   mapped_due[$];
    int                          mismatch_count;
    int                          send_idle_pct;
    int                          rcv_stall_pct;
    int                          hold_left;

    piecewise_linear_tone_curve_unit u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_pixel_value  (i_pixel_value),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_mapped_value (o_mapped_value)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Run limit
    initial begin
        #3_000_000;
        $display("** piecewise_linear_tone_curve_unit: FAILED **");
        $finish;
    end

    function automatic int knot_x(input int k);
        return int'(knot_x_reg[k*plt_pkg::PIX_W +: plt_pkg::PIX_W]);
    endfunction

    function automatic int knot_y(input int k);
        return int'(knot_y_reg[k*plt_pkg::PIX_W +: plt_pkg::PIX_W]);
    endfunction

    // Expected tone-curve output for one pixel
    function automatic logic [plt_pkg::PIX_W-1:0] tone_map(
        input logic [plt_pkg::PIX_W-1:0] pix
    );
        int seg;
        int p;
        int xl;
        int yl;
        int yh;
        int dx;
        int t;
        p   = int'(pix);
        seg = 0;
        while (seg < KNOTS && knot_x(seg) < p) seg++;
        if (seg >= KNOTS) return plt_pkg::PIX_W'(knot_y(KNOTS-1));
        if (seg == 0 || knot_x(seg) == p) return plt_pkg::PIX_W'(knot_y(seg));
        xl = knot_x(seg-1);
        yl = knot_y(seg-1);
        yh = knot_y(seg);
        dx = knot_x(seg) - xl;
        t  = p - xl;
        if (yh >= yl) return plt_pkg::PIX_W'(yl + (t * (yh - yl)) / dx);
        // falling segment: floor of the exact value
        return plt_pkg::PIX_W'(yl - (t * (yl - yh) + dx - 1) / dx);
    endfunction

    // Output side: random stall, plus long hold-off when requested
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                i_stall <= 1'b1;
                hold_left = hold_left - 1;
            end else begin
                i_stall <= ($urandom_range(0, 99) < rcv_stall_pct);
            end
        end
    end

    // Result checker
    initial begin
        logic [plt_pkg::PIX_W-1:0] want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && !i_stall) begin
                if (mapped_due.size() == 0) begin
                    $error("mapped_value: expected none, actual %0d", o_mapped_value);
                    mismatch_count++;
                end else begin
                    want = mapped_due.pop_front();
                    if (o_mapped_value !== want) begin
                        $error("mapped_value: expected %0d, actual %0d",
                               want, o_mapped_value);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    // Offer one pixel, with random idle cycles ahead of it
    task automatic send_pixel(input logic [plt_pkg::PIX_W-1:0] pix);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid       <= 1'b1;
        i_pixel_value <= pix;
        do @(posedge i_clk); while (o_stall);
        mapped_due.push_back(tone_map(pix));
    endtask

    // Stop offering and wait for every outstanding result
    task automatic drain;
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (mapped_due.size() != 0) @(posedge i_clk);
    endtask

    // Register write, only with the pipeline empty
    task automatic write_reg(input plt_pkg::t_cfg_idx idx,
                             input logic [plt_pkg::CFG_W-1:0] val);
        drain();
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        if (idx == plt_pkg::CFG_KNOT_X) knot_x_reg = val;
        else                            knot_y_reg = val;
    endtask

    task automatic set_curve(input logic [plt_pkg::CFG_W-1:0] xs,
                             input logic [plt_pkg::CFG_W-1:0] ys);
        write_reg(plt_pkg::CFG_KNOT_X, xs);
        write_reg(plt_pkg::CFG_KNOT_Y, ys);
    endtask

    function automatic logic [plt_pkg::CFG_W-1:0] rand_word();
        return plt_pkg::CFG_W'({$urandom, $urandom});
    endfunction

    // Strictly increasing knot positions spread over the pixel range
    function automatic logic [plt_pkg::CFG_W-1:0] rand_rising_x();
        logic [plt_pkg::CFG_W-1:0] xs;
        int prev;
        int span;
        int step;
        xs   = '0;
        prev = $urandom_range(0, 60);
        xs[plt_pkg::PIX_W-1:0] = plt_pkg::PIX_W'(prev);
        for (int k = 1; k < plt_pkg::MAX_KNOTS; k++) begin
            span = (255 - prev) - (plt_pkg::MAX_KNOTS - 1 - k);
            step = $urandom_range(1, ((span + 5) / (plt_pkg::MAX_KNOTS - k)) * 2);
            if (step > span) step = span;
            prev = prev + step;
            xs[k*plt_pkg::PIX_W +: plt_pkg::PIX_W] = plt_pkg::PIX_W'(prev);
        end
        return xs;
    endfunction

    // Pixels at the reset curve's knots, around them and at the range ends
    task automatic test_reset_curve;
        logic [plt_pkg::PIX_W-1:0] pix_list[$];
        pix_list = '{8'd0, 8'd1, 8'd49, 8'd50, 8'd51, 8'd100, 8'd127,
                     8'd200, 8'd201, 8'd254, 8'd255};
        foreach (pix_list[i]) send_pixel(pix_list[i]);
    endtask

    // Falling segments, offset ends, unordered knots and flat extremes
    task automatic test_edge_curves;
        // x = 10,40,90,160,200,240 / y = 255,200,201,100,30,0
        set_curve(48'hF0_C8_A0_5A_28_0A, 48'h00_1E_64_C9_C8_FF);
        send_pixel(8'd5);      // below first knot
        send_pixel(8'd10);
        send_pixel(8'd25);     // falling
        send_pixel(8'd60);     // rising
        send_pixel(8'd220);    // falling last segment
        send_pixel(8'd250);    // above last knot
        // x = 100,50,200,20,150,30: knots out of order
        set_curve(48'h1E_96_14_C8_32_64, 48'hFF_00_E0_30_A5_0A);
        send_pixel(8'd100);
        send_pixel(8'd60);
        send_pixel(8'd120);
        send_pixel(8'd210);
        // all knots at zero / all at full scale
        set_curve('0, ALL_ONES);
        send_pixel(8'd0);
        send_pixel(8'd1);
        set_curve(ALL_ONES, '0);
        send_pixel(8'd255);
        send_pixel(8'd0);
    endtask

    // Random curves, each followed by random pixels
    task automatic test_random_curves(input int n_curves, input int n_pixels);
        t_curve_shape shape;
        logic [plt_pkg::CFG_W-1:0] xs;
        logic [plt_pkg::CFG_W-1:0] ys;
        for (int c = 0; c < n_curves; c++) begin
            shape = t_curve_shape'($urandom_range(0, 3));
            ys    = rand_word();
            case (shape)
                CURVE_RISING: begin
                    xs = rand_rising_x();
                end
                CURVE_SCRAMBLED: begin
                    // mostly rising with one knot pushed out of place
                    xs = rand_rising_x();
                    xs[$urandom_range(0, plt_pkg::MAX_KNOTS-1)*plt_pkg::PIX_W
                       +: plt_pkg::PIX_W] = plt_pkg::PIX_W'($urandom);
                end
                CURVE_RAW: begin
                    xs = rand_word();
                end
                default: begin
                    xs = $urandom_range(0, 1) ? ALL_ONES : plt_pkg::KNOT_X_RST;
                    if ($urandom_range(0, 2) == 0) xs = '0;
                    ys = $urandom_range(0, 1) ? ALL_ONES : '0;
                end
            endcase
            set_curve(xs, ys);
            for (int i = 0; i < n_pixels; i++) begin
                if ($urandom_range(0, 3) == 0)
                    send_pixel(xs[$urandom_range(0, plt_pkg::MAX_KNOTS-1)*plt_pkg::PIX_W
                                  +: plt_pkg::PIX_W]);
                else
                    send_pixel(plt_pkg::PIX_W'($urandom));
            end
        end
    endtask

    // Output held off for a long stretch while pixels keep coming
    task automatic test_backpressure;
        set_curve(rand_rising_x(), rand_word());
        hold_left = 250;
        for (int i = 0; i < 80; i++) send_pixel(plt_pkg::PIX_W'($urandom));
    endtask

    initial begin
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_idx      = plt_pkg::CFG_KNOT_X;
        i_cfg_data     = '0;
        i_valid        = 1'b0;
        i_pixel_value  = '0;
        i_stall        = 1'b0;
        knot_x_reg     = plt_pkg::KNOT_X_RST;
        knot_y_reg     = plt_pkg::KNOT_Y_RST;
        mismatch_count = 0;
        hold_left      = 0;
        send_idle_pct  = 7;
        rcv_stall_pct  = 74;

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_curve();
        test_edge_curves();
        test_random_curves(5, 50);

        send_idle_pct = 74;
        rcv_stall_pct = 7;
        test_random_curves(5, 50);

        send_idle_pct = 0;
        rcv_stall_pct = 0;
        test_backpressure();
        test_random_curves(5, 50);

        // let any stray result show up
        drain();
        repeat (LATENCY + 8) @(posedge i_clk);
        if (mismatch_count == 0 && mapped_due.size() == 0) begin
            $display("** piecewise_linear_tone_curve_unit: PASSED **");
        end else begin
            $display("** piecewise_linear_tone_curve_unit: FAILED **");
        end
        $finish;
    end

endmodule

// ----- piecewise_linear_tone_curve_unit.f -----
rtl/plt_pkg.sv
rtl/plt_search_cell.sv
rtl/plt_div_cell.sv
rtl/piecewise_linear_tone_curve_unit.sv
dv/testbench.sv
